// ===== rtl/ulsv_pkg.sv =====
// Shared types, constants and codes of the UTF-8 line splitter and validator.
package ulsv_pkg;

    // Field and counter widths.
    localparam int TEXT_W       = 25;
    localparam int LINE_BYTES_W = 17;
    localparam int LINES_W      = 19;
    localparam int COL_W        = 19;
    localparam int CP_W         = 21;
    localparam int CFG_W        = 25;

    // Columns a tab may advance to reach the next stop.
    localparam int TAB_STOP = 4;
    localparam int TAB_W    = $clog2(TAB_STOP + 1);

    // Saturation limits.
    localparam logic [COL_W-1:0]  COL_MAX      = '1;
    localparam logic [TEXT_W-1:0] TEXT_CNT_MAX = '1;

    // Configuration values after reset.
    localparam logic [TEXT_W-1:0]       MAX_TEXT_RST  = TEXT_W'(8388608);
    localparam logic [LINE_BYTES_W-1:0] MAX_LINE_RST  = LINE_BYTES_W'(65536);
    localparam logic [LINES_W-1:0]      MAX_LINES_RST = LINES_W'(200000);

    // UTF-8 and code point constants.
    localparam logic [7:0]      BYTE_LF       = 8'h0A;
    localparam logic [7:0]      BYTE_CR       = 8'h0D;
    localparam logic [7:0]      LEAD2_LO      = 8'hC2;
    localparam logic [7:0]      LEAD2_HI      = 8'hDF;
    localparam logic [7:0]      LEAD3_LO      = 8'hE0;
    localparam logic [7:0]      LEAD3_HI      = 8'hEF;
    localparam logic [7:0]      LEAD4_LO      = 8'hF0;
    localparam logic [7:0]      LEAD4_HI      = 8'hF4;
    localparam logic [CP_W-1:0] CP_TAB        = CP_W'(9);
    localparam logic [CP_W-1:0] CP_SPACE      = CP_W'(32);
    localparam logic [CP_W-1:0] CP_DEL        = CP_W'(127);
    localparam logic [CP_W-1:0] CP_MIN2       = CP_W'(24'h80);
    localparam logic [CP_W-1:0] CP_MIN3       = CP_W'(24'h800);
    localparam logic [CP_W-1:0] CP_MIN4       = CP_W'(24'h10000);
    localparam logic [CP_W-1:0] CP_MAX        = CP_W'(24'h10FFFF);
    localparam logic [CP_W-1:0] CP_SURR_LO    = CP_W'(24'hD800);
    localparam logic [CP_W-1:0] CP_SURR_HI    = CP_W'(24'hDFFF);
    localparam logic [CP_W-1:0] CP_BOM        = CP_W'(24'hFEFF);
    localparam logic [TEXT_W-1:0] BOM_LAST_POS = TEXT_W'(3);

    // Result queue sizing.
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_PARTIAL  = 3'd0,
        KIND_CHAR     = 3'd1,
        KIND_TAB      = 3'd2,
        KIND_LINE_END = 3'd3,
        KIND_DROPPED  = 3'd4,
        KIND_ERROR    = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TEXT_SIZE = 3'd1,
        ERR_UTF8      = 3'd2,
        ERR_LINE_LONG = 3'd3,
        ERR_CONTROL   = 3'd4,
        ERR_LINES     = 3'd5
    } t_err;

    typedef enum logic [1:0] {
        CFG_MAX_TEXT  = 2'd0,
        CFG_MAX_LINE  = 2'd1,
        CFG_MAX_LINES = 2'd2
    } t_cfg_idx;

    // One input beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_text;
    } t_item;

    // One result beat.
    typedef struct packed {
        t_kind              kind;
        logic [CP_W-1:0]    code_point;
        logic [2:0]         columns_added;
        logic [COL_W-1:0]   column_now;
        logic [LINES_W-1:0] line_number;
        logic [COL_W-1:0]   widest_line;
        t_err               error_code;
        logic               last_result;
    } t_res;

    // Results of one item handed to the result queue.
    typedef struct packed {
        logic [1:0] cnt;
        t_res       first;
        t_res       second;
    } t_push;

endpackage

// ===== rtl/utf8_line_splitter_validator.sv =====
// Top level of the UTF-8 line splitter and validator: input register, step logic, result queue.
//
// The block takes one input beat per cycle while o_stall is low and answers each with zero,
// one or two result beats: one for a present byte and one more for an end-of-text mark. The
// input beat is registered, then decoded and checked combinationally against the text state,
// and its results are written into a four-entry result queue that drives the output.
// The output gives one beat per cycle while i_stall is low; the input is
// stalled only when the queue lacks room for two beats, which happens when the output
// side stalls or when items that carry both a byte and an end mark come back to back.
// Limit registers are to be written by the user through the configuration port while no text is in
// flight; the block itself does not enforce this.
module utf8_line_splitter_validator
    import ulsv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_item            i_item,
    output logic             o_valid,
    input  logic             i_stall,
    output t_res             o_res
);

    logic  r_in_vld;
    t_item r_in;
    logic  fire;
    logic  room;
    t_push push;

    // The registered beat is processed when the queue has room for both possible results.
    assign fire    = r_in_vld && room;
    assign o_stall = r_in_vld && !room;

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_item;
        end
    end

    ulsv_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_item     (r_in),
        .o_push     (push)
    );

    ulsv_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    a_fire_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !(i_valid && !o_stall)) |=> !r_in_vld)
        else $error("input register not emptied after its beat was processed");
    a_push_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.cnt != 2'd0) |-> fire)
        else $error("result beats pushed without a processed input beat");
    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_vld && !fire))
        else $error("input stalled while the input register could move");
`endif

endmodule

// ===== rtl/ulsv_res_fifo.sv =====
// Four-entry result queue that takes up to two beats and gives one beat per cycle unless the output stalls.
module ulsv_res_fifo
    import ulsv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_room,
    output logic  o_valid,
    input  logic  i_stall,
    output t_res  o_res
);

    t_res                 r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wp;
    logic [RES_PTR_W-1:0] r_rp;
    logic [RES_CNT_W-1:0] r_cnt;
    logic [RES_PTR_W-1:0] n_wp1;
    logic [RES_PTR_W-1:0] n_wp2;
    logic [RES_PTR_W-1:0] n_rp;
    logic                 pop;

    function automatic logic [RES_PTR_W-1:0] ptr_inc(input logic [RES_PTR_W-1:0] p);
        ptr_inc = (p == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Room for the two beats that one item may produce.
    assign o_room  = (r_cnt <= RES_CNT_W'(RES_DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rp];
    assign pop     = o_valid && !i_stall;

    // Pointer steps.
    always_comb begin
        n_wp1 = ptr_inc(r_wp);
        n_wp2 = ptr_inc(n_wp1);
        n_rp  = ptr_inc(r_rp);
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[n_wp1] <= i_push.second;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.cnt == 2'd1) begin
                r_wp <= n_wp1;
            end else if (i_push.cnt == 2'd2) begin
                r_wp <= n_wp2;
            end
            if (pop) begin
                r_rp <= n_rp;
            end
            r_cnt <= r_cnt + RES_CNT_W'(i_push.cnt) - RES_CNT_W'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> (r_cnt <= RES_CNT_W'(RES_DEPTH - 2)))
        else $error("result beats pushed without room");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue count out of range");
`endif

endmodule

// ===== rtl/ulsv_step.sv =====
// Per-item decode, validation, line and column tracking, with state and limit registers.
module ulsv_step
    import ulsv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_fire,
    input  t_item             i_item,
    output t_push             o_push
);

    // Limit registers.
    logic [TEXT_W-1:0]       r_max_text;
    logic [LINE_BYTES_W-1:0] r_max_line;
    logic [LINES_W-1:0]      r_max_lines;

    // Text state.
    logic [1:0]              r_rem;
    logic [2:0]              r_len;
    logic [CP_W-1:0]         r_acc;
    logic                    r_cr;
    logic [TEXT_W-1:0]       r_tbc;
    logic [LINE_BYTES_W-1:0] r_lbc;
    logic [COL_W-1:0]        r_col;
    logic [COL_W-1:0]        r_wid;
    logic [LINES_W-1:0]      r_fl;
    t_err                    r_err;

    // Working copies of the state while one item is processed.
    logic [1:0]              v_rem;
    logic [2:0]              v_len;
    logic [CP_W-1:0]         v_acc;
    logic                    v_cr;
    logic [TEXT_W-1:0]       v_tbc;
    logic [LINE_BYTES_W-1:0] v_lbc;
    logic [COL_W-1:0]        v_col;
    logic [COL_W-1:0]        v_wid;
    logic [LINES_W-1:0]      v_fl;
    t_err                    v_err;

    logic [7:0]              b;
    logic                    have_char;
    logic                    do_fin;
    logic                    bad;
    logic [CP_W-1:0]         ccp;
    logic [2:0]              clen;
    logic [2:0]              lead_len;
    logic [TAB_W-1:0]        tab_add;
    logic [COL_W:0]          col_sum;
    t_res                    res_byte;
    t_res                    res_eot;

    function automatic logic [LINES_W-1:0] cur_line(input logic [LINES_W-1:0] fl);
        cur_line = (fl == COL_MAX) ? fl : fl + 1'b1;
    endfunction

    function automatic t_res mk(input t_kind k, input logic [CP_W-1:0] cp,
                                input logic [2:0] add, input logic [LINES_W-1:0] line,
                                input logic [COL_W-1:0] col, input logic [COL_W-1:0] wid,
                                input t_err e);
        t_res r;
        r.kind          = k;
        r.code_point    = cp;
        r.columns_added = add;
        r.column_now    = col;
        r.line_number   = line;
        r.widest_line   = wid;
        r.error_code    = (k == KIND_ERROR) ? e : ERR_NONE;
        r.last_result   = 1'b0;
        mk = r;
    endfunction

    // Byte step followed by the end-of-text step, in that order.
    always_comb begin
        v_rem = r_rem;
        v_len = r_len;
        v_acc = r_acc;
        v_cr  = r_cr;
        v_tbc = r_tbc;
        v_lbc = r_lbc;
        v_col = r_col;
        v_wid = r_wid;
        v_fl  = r_fl;
        v_err = r_err;
        b         = i_item.data_byte;
        have_char = 1'b0;
        do_fin    = 1'b0;
        bad       = 1'b0;
        ccp       = '0;
        clen      = 3'd0;
        lead_len  = 3'd0;
        tab_add   = '0;
        col_sum   = '0;
        res_byte  = mk(KIND_PARTIAL, '0, 3'd0, cur_line(r_fl), r_col, r_wid, r_err);
        res_eot   = res_byte;

        // Byte intake and sequence assembly.
        if (i_item.byte_present) begin
            if (v_tbc != TEXT_CNT_MAX) begin
                v_tbc = v_tbc + 1'b1;
            end
            if (v_err != ERR_NONE) begin
                res_byte = mk(KIND_ERROR, '0, 3'd0, cur_line(v_fl), v_col, v_wid, v_err);
            end else if (v_tbc > r_max_text) begin
                v_err    = ERR_TEXT_SIZE;
                res_byte = mk(KIND_ERROR, '0, 3'd0, cur_line(v_fl), v_col, v_wid, v_err);
            end else if (v_rem != 2'd0) begin
                if (b[7:6] != 2'b10) begin
                    v_err    = ERR_UTF8;
                    res_byte = mk(KIND_ERROR, '0, 3'd0, cur_line(v_fl), v_col, v_wid, v_err);
                end else begin
                    v_acc = {v_acc[CP_W-7:0], b[5:0]};
                    v_rem = v_rem - 1'b1;
                    if (v_rem != 2'd0) begin
                        res_byte = mk(KIND_PARTIAL, '0, 3'd0, cur_line(v_fl), v_col, v_wid,
                                      v_err);
                    end else begin
                        have_char = 1'b1;
                        ccp       = v_acc;
                        clen      = v_len;
                    end
                end
            end else if (v_cr && b == BYTE_LF) begin
                v_cr     = 1'b0;
                res_byte = mk(KIND_DROPPED, '0, 3'd0, cur_line(v_fl), v_col, v_wid, v_err);
            end else begin
                v_cr = 1'b0;
                if (b == BYTE_CR) begin
                    v_cr   = 1'b1;
                    do_fin = 1'b1;
                end else if (b == BYTE_LF) begin
                    do_fin = 1'b1;
                end else if (!b[7]) begin
                    have_char = 1'b1;
                    ccp       = CP_W'(b);
                    clen      = 3'd1;
                end else begin
                    if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                        lead_len = 3'd2;
                    end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                        lead_len = 3'd3;
                    end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                        lead_len = 3'd4;
                    end
                    if (lead_len == 3'd0) begin
                        v_err    = ERR_UTF8;
                        res_byte = mk(KIND_ERROR, '0, 3'd0, cur_line(v_fl), v_col, v_wid,
                                      v_err);
                    end else begin
                        v_len    = lead_len;
                        v_rem    = 2'(lead_len - 3'd1);
                        v_acc    = CP_W'(b & (8'h7F >> lead_len));
                        res_byte = mk(KIND_PARTIAL, '0, 3'd0, cur_line(v_fl), v_col, v_wid,
                                      v_err);
                    end
                end
            end

            // Line end from CR or LF.
            if (do_fin) begin
                if (v_fl >= r_max_lines) begin
                    v_err    = ERR_LINES;
                    res_byte = mk(KIND_ERROR, '0, 3'd0, cur_line(v_fl), v_col, v_wid, v_err);
                end else begin
                    if (v_col > v_wid) begin
                        v_wid = v_col;
                    end
                    v_fl     = v_fl + 1'b1;
                    v_col    = '0;
                    v_lbc    = '0;
                    res_byte = mk(KIND_LINE_END, '0, 3'd0, v_fl, v_col, v_wid, v_err);
                end
            end

            // Complete character: form checks, BOM, line bytes, tab and control.
            if (have_char) begin
                bad = (clen == 3'd2 && ccp < CP_MIN2) || (clen == 3'd3 && ccp < CP_MIN3) ||
                      (clen == 3'd4 && ccp < CP_MIN4) || (ccp > CP_MAX) ||
                      (ccp >= CP_SURR_LO && ccp <= CP_SURR_HI);
                if (bad) begin
                    v_err    = ERR_UTF8;
                    res_byte = mk(KIND_ERROR, '0, 3'd0, cur_line(v_fl), v_col, v_wid, v_err);
                end else if (ccp == CP_BOM && clen == 3'd3 && v_tbc == BOM_LAST_POS) begin
                    res_byte = mk(KIND_DROPPED, '0, 3'd0, cur_line(v_fl), v_col, v_wid,
                                  v_err);
                end else if ((18'(v_lbc) + 18'(clen)) > 18'(r_max_line)) begin
                    v_err    = ERR_LINE_LONG;
                    res_byte = mk(KIND_ERROR, '0, 3'd0, cur_line(v_fl), v_col, v_wid, v_err);
                end else begin
                    v_lbc = v_lbc + LINE_BYTES_W'(clen);
                    if (ccp == CP_TAB) begin
                        tab_add = TAB_W'(TAB_STOP) - TAB_W'(v_col % TAB_STOP);
                        col_sum = {1'b0, v_col} + (COL_W + 1)'(tab_add);
                        v_col   = (col_sum > (COL_W + 1)'(COL_MAX)) ? COL_MAX
                                                                    : col_sum[COL_W-1:0];
                        res_byte = mk(KIND_TAB, '0,
                                      (int'(tab_add) > 7) ? 3'd7 : 3'(tab_add),
                                      cur_line(v_fl), v_col, v_wid, v_err);
                    end else if (ccp < CP_SPACE || ccp == CP_DEL) begin
                        v_err    = ERR_CONTROL;
                        res_byte = mk(KIND_ERROR, '0, 3'd0, cur_line(v_fl), v_col, v_wid,
                                      v_err);
                    end else begin
                        if (v_col != COL_MAX) begin
                            v_col = v_col + 1'b1;
                        end
                        res_byte = mk(KIND_CHAR, ccp, 3'd1, cur_line(v_fl), v_col, v_wid,
                                      v_err);
                    end
                end
            end
        end

        // End of text: report a pending error or close the final line.
        if (i_item.end_of_text) begin
            if (v_err == ERR_NONE && v_rem != 2'd0) begin
                v_err = ERR_UTF8;
            end
            if (v_err != ERR_NONE) begin
                res_eot = mk(KIND_ERROR, '0, 3'd0, cur_line(v_fl), v_col, v_wid, v_err);
            end else if (v_fl >= r_max_lines) begin
                v_err   = ERR_LINES;
                res_eot = mk(KIND_ERROR, '0, 3'd0, cur_line(v_fl), v_col, v_wid, v_err);
            end else begin
                if (v_col > v_wid) begin
                    v_wid = v_col;
                end
                v_fl    = v_fl + 1'b1;
                v_col   = '0;
                v_lbc   = '0;
                res_eot = mk(KIND_LINE_END, '0, 3'd0, v_fl, v_col, v_wid, v_err);
            end
            res_eot.last_result = 1'b1;
        end
        res_byte.last_result = !i_item.end_of_text;
    end

    // Order the beats of this item for the result queue.
    always_comb begin
        o_push.cnt    = 2'd0;
        o_push.first  = res_byte;
        o_push.second = res_eot;
        if (i_fire) begin
            o_push.cnt = 2'(i_item.byte_present) + 2'(i_item.end_of_text);
            if (!i_item.byte_present) begin
                o_push.first = res_eot;
            end
        end
    end

    // Limit registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_text  <= MAX_TEXT_RST;
            r_max_line  <= MAX_LINE_RST;
            r_max_lines <= MAX_LINES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_TEXT:  r_max_text  <= i_cfg_data[TEXT_W-1:0];
                CFG_MAX_LINE:  r_max_line  <= i_cfg_data[LINE_BYTES_W-1:0];
                CFG_MAX_LINES: r_max_lines <= i_cfg_data[LINES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Text state; the end of a text returns it to the reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.end_of_text)) begin
            r_rem <= '0;
            r_len <= '0;
            r_acc <= '0;
            r_cr  <= 1'b0;
            r_tbc <= '0;
            r_lbc <= '0;
            r_col <= '0;
            r_wid <= '0;
            r_fl  <= '0;
            r_err <= ERR_NONE;
        end else if (i_fire) begin
            r_rem <= v_rem;
            r_len <= v_len;
            r_acc <= v_acc;
            r_cr  <= v_cr;
            r_tbc <= v_tbc;
            r_lbc <= v_lbc;
            r_col <= v_col;
            r_wid <= v_wid;
            r_fl  <= v_fl;
            r_err <= v_err;
        end
    end

`ifndef SYNTHESIS
    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.end_of_text) |=>
        (r_fl == '0 && r_err == ERR_NONE && r_rem == 2'd0 && r_tbc == '0))
        else $error("text state not cleared after end of text");
    a_seq_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem != 2'd0) |-> ((r_len == 3'd2 || r_len == 3'd3 || r_len == 3'd4) &&
                             (3'(r_rem) < r_len)))
        else $error("pending continuation count does not fit the sequence length");
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.cnt != 2'd0 && o_push.first.kind == KIND_ERROR) |->
        (o_push.first.error_code != ERR_NONE))
        else $error("error beat without an error code");
`endif

endmodule
